/* design/itoa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // Digit store geometry: ten decimal digits cover any 32-bit magnitude
  localparam int unsigned StoreDepth = 10;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned StoreBits  = StoreDepth * DigitW;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CharW      = 7;

  // ASCII codes and radix constants
  localparam logic [CharW-1:0]  ZeroCode  = 7'd48;
  localparam logic [CharW-1:0]  UpperA    = 7'd65;
  localparam logic [CharW-1:0]  LowerA    = 7'd97;
  localparam logic [CharW-1:0]  MinusCode = 7'd45;
  localparam logic [DigitW-1:0] Ten       = 4'd10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_COUNT,
    S_SIGN,
    S_EMIT
  } itoa_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_hex;
    logic negative;
    logic last_step;
    logic idx_zero;
    logic out_free;
  } dp_status_t;

  // Map one digit to its ASCII code
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                  input logic upper);
    logic [CharW-1:0] base;
    base = upper ? UpperA : LowerA;
    if (d < Ten) begin
      return ZeroCode + CharW'(d);
    end
    return base + CharW'(d - Ten);
  endfunction

endpackage

`default_nettype wire

/* design/integer_to_ascii_radix_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake              | Payload
// in      | in_valid_i, in_ready_o | value_i[31:0], use_hex_i, upper_case_i
// out     | out_valid_o, out_ready_i | character_o[6:0], last_o
//
// Decimal: a load, the double-dabble shifts over the low min(VALUE_WIDTH,32) bits,
//   a digit scan, then the characters (sign plus digits).
// Hex: a load, a pass through the conversion state, a scan, then the characters.
// The double-dabble shift loop sits in the datapath and is used for decimal only.
// Reset is asynchronous, active low; the digit store is not reset.
// An output stall holds the character loop; the next item is taken once
// the last character sits in the output register.

module integer_to_ascii_radix_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [31:0]                 value_i,
  input  wire                         use_hex_i,
  input  wire                         upper_case_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [itoa_pkg::CharW-1:0]  character_o,
  output logic                        last_o
);
  import itoa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .use_hex_i    (use_hex_i),
    .upper_case_i (upper_case_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

  // A load never overlaps any other datapath command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !(cmd.step || cmd.emit_sign || cmd.emit_digit))
    else $error("load overlaps another command");

  // A character is only written when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
    else $error("character written over a pending beat");

  // Input is blocked right after a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ready_o)
    else $error("input ready during conversion");

  // The final digit returns the block to accepting input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_digit && status.idx_zero) |=> (in_ready_o && out_valid_o && last_o))
    else $error("final digit did not finish the number");

endmodule

`default_nettype wire

/* design/itoa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module itoa_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  itoa_pkg::dp_status_t   status_i,
  output itoa_pkg::dp_cmd_t      cmd_o
);
  import itoa_pkg::*;

  itoa_state_e state_d, state_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CONV;
      end
      S_CONV: begin
        if (status_i.is_hex || status_i.last_step) state_d = S_COUNT;
      end
      S_COUNT: begin
        state_d = status_i.negative ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (status_i.out_free) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free && status_i.idx_zero) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CONV: begin
        cmd_o.step = !status_i.is_hex;
      end
      S_COUNT: begin
        cmd_o.count = 1'b1;
      end
      S_SIGN: begin
        cmd_o.emit_sign = status_i.out_free;
      end
      S_EMIT: begin
        cmd_o.emit_digit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/itoa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module itoa_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [31:0]                  value_i,
  input  wire                          use_hex_i,
  input  wire                          upper_case_i,
  input  itoa_pkg::dp_cmd_t            cmd_i,
  output itoa_pkg::dp_status_t         status_o,
  input  wire                          out_ready_i,
  output logic                         out_valid_o,
  output logic [itoa_pkg::CharW-1:0]   character_o,
  output logic                         last_o
);
  import itoa_pkg::*;

  localparam int unsigned EffW   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam bit          SignOk = (VALUE_WIDTH <= 32);
  localparam int unsigned CntW   = $clog2(EffW + 1);
  localparam logic [DigitW-1:0] DabbleLimit = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd   = 4'd3;

  logic [EffW-1:0] in_bits;
  logic            in_neg;
  logic [EffW-1:0] mag_d, mag_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [StoreDepth-1:0][DigitW-1:0] digit_d, digit_q, adj;
  logic [StoreBits-1:0] adj_flat;
  logic [IdxW-1:0] idx_d, idx_q, top_idx;
  logic            hex_q, upper_q, neg_q;
  logic            out_valid_q;
  logic [CharW-1:0] char_q;
  logic            last_q;
  logic            emit;

  // Select the low bits and decide the sign
  assign in_bits = value_i[EffW-1:0];
  assign in_neg  = SignOk && !use_hex_i && in_bits[EffW-1];

  // Add three to each digit of five or more ahead of the shift
  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      adj[i] = (digit_q[i] >= DabbleLimit) ? digit_q[i] + DabbleAdd : digit_q[i];
    end
  end
  assign adj_flat = adj;

  // Find the highest nonzero digit
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < StoreDepth; i++) begin
      if (digit_q[i] != '0) top_idx = IdxW'(i);
    end
  end

  // Load, shift, count and step the digit index
  always_comb begin
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    digit_d = digit_q;
    idx_d   = idx_q;
    priority if (cmd_i.load) begin
      mag_d = in_neg ? (~in_bits) + EffW'(1) : in_bits;
      cnt_d = CntW'(EffW);
      if (use_hex_i) begin
        digit_d = StoreBits'(in_bits);
      end else begin
        digit_d = '0;
      end
    end else if (cmd_i.step) begin
      digit_d = {adj_flat[StoreBits-2:0], mag_q[EffW-1]};
      mag_d   = mag_q << 1;
      cnt_d   = cnt_q - CntW'(1);
    end else if (cmd_i.count) begin
      idx_d = top_idx;
    end else if (cmd_i.emit_digit && idx_q != '0) begin
      idx_d = idx_q - IdxW'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  // Control and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      hex_q   <= 1'b0;
      upper_q <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      mag_q <= mag_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (cmd_i.load) begin
        hex_q   <= use_hex_i;
        upper_q <= upper_case_i;
        neg_q   <= in_neg;
      end
    end
  end

  // Digit store
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  // Output beat register
  assign emit = cmd_i.emit_sign || cmd_i.emit_digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q <= MinusCode;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= digit_char(digit_q[idx_q], upper_q);
      last_q <= (idx_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Status toward the controller
  assign status_o.is_hex    = hex_q;
  assign status_o.negative  = neg_q;
  assign status_o.last_step = (cnt_q == CntW'(1));
  assign status_o.idx_zero  = (idx_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
